>>> rtl/pib_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pib_pkg
// Shared constants, types and sat32/sext64 helpers for the particle integrator.
// ----------------------------------------------------------------------------
package pib_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 32 + FRAC_BITS;

  localparam logic signed [63:0] EPS64 =
    ((64'sd1 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000;

  localparam logic [2:0] REG_GRAVITY = 3'd0;
  localparam logic [2:0] REG_DT      = 3'd1;
  localparam logic [2:0] REG_RADIUS  = 3'd2;
  localparam logic [2:0] REG_HALF_W  = 3'd3;
  localparam logic [2:0] REG_BOUNCE  = 3'd4;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [2:0]         neg;
    logic               fault;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sext64(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage
`default_nettype wire

>>> rtl/pib_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pib_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pib_div
  import pib_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [30:0]      den,
  output logic      [NUM_W-1:0] quo
);

  logic [30:0]      rem_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [30:0]      den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [30:0]      rem_i;
    logic [NUM_W-1:0] num_i;
    logic [NUM_W-1:0] quo_i;
    logic [30:0]      den_i;
    logic [31:0]      rem_sh;
    logic [32:0]      diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign num_i = num;
      assign quo_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign num_i = num_q[k-1];
      assign quo_i = quo_q[k-1];
      assign den_i = den_q[k-1];
    end

    assign rem_sh = {rem_i, num_i[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_i};
    assign ge     = ~diff[32];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[30:0] : rem_sh[30:0];
        num_q[k] <= {num_i[NUM_W-2:0], 1'b0};
        quo_q[k] <= {quo_i[NUM_W-2:0], ge};
        den_q[k] <= den_i;
      end
    end
  end

  assign quo = quo_q[NUM_W-1];

endmodule
`default_nettype wire

>>> rtl/particle_integrate_box_bounce_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_integrate_box_bounce_core
// Symplectic Euler particle step with box wall reflection, Q16.16.
// Most of the pipe is the bit-per-stage divider lanes.
// Throughput: one request per cycle; the whole pipe stalls on output back
// pressure. Synchronous reset clears valid bits and loads default registers.
// ----------------------------------------------------------------------------
module particle_integrate_box_bounce_core
  import pib_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] particle_id,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] vel_x,
  input  wire logic [31:0] vel_y,
  input  wire logic [31:0] vel_z,
  input  wire logic [31:0] force_x,
  input  wire logic [31:0] force_y,
  input  wire logic [31:0] force_z,
  input  wire logic [31:0] fluid_density,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_id,
  output logic [31:0]      new_pos_x,
  output logic [31:0]      new_pos_y,
  output logic [31:0]      new_pos_z,
  output logic [31:0]      new_vel_x,
  output logic [31:0]      new_vel_y,
  output logic [31:0]      new_vel_z,
  output logic             density_fault
);

  logic signed [31:0] gravity;
  logic [30:0]        time_step;
  logic [30:0]        radius;
  logic [30:0]        half_w;
  logic [16:0]        bounce;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= -32'sd642253;
      time_step <= 31'd655;
      radius    <= 31'd6554;
      half_w    <= 31'd196608;
      bounce    <= 17'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRAVITY: gravity   <= cfg_data;
        REG_DT:      time_step <= cfg_data[30:0];
        REG_RADIUS:  radius    <= cfg_data[30:0];
        REG_HALF_W:  half_w    <= cfg_data[30:0];
        REG_BOUNCE:  bounce    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  logic signed [63:0] dt64, e64, hh64, lo64;
  assign dt64 = $signed({33'd0, time_step});
  assign e64  = $signed({47'd0, bounce});
  assign hh64 = $signed({33'd0, radius});
  assign lo64 = hh64 - $signed({33'd0, half_w});

  // divider lanes
  logic [31:0]      frc [3];
  logic [2:0]       fneg;
  logic [31:0]      fmag [3];
  logic [NUM_W-1:0] quo [3];
  logic             fault_in;

  assign frc[0]   = force_x;
  assign frc[1]   = force_y;
  assign frc[2]   = force_z;
  assign fault_in = ($signed(fluid_density) <= 32'sd0);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign fneg[i] = frc[i][31];
    assign fmag[i] = fneg[i] ? (32'd0 - frc[i]) : frc[i];
    pib_div u_div (
      .clk (clk),
      .en  (en),
      .num ({fmag[i], {FRAC_BITS{1'b0}}}),
      .den (fluid_density[30:0]),
      .quo (quo[i])
    );
  end

  side_t side_in;
  side_t side_q [NUM_W];
  logic  vld_q  [NUM_W];

  assign side_in = '{id: particle_id, px: pos_x, py: pos_y, pz: pos_z,
                     vx: vel_x, vy: vel_y, vz: vel_z, neg: fneg, fault: fault_in};

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < NUM_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_W; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid;
      for (int k = 1; k < NUM_W; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  side_t              sd;
  logic signed [31:0] qs [3];
  assign sd = side_q[NUM_W-1];

  for (genvar i = 0; i < 3; i++) begin : g_qsat
    always_comb begin
      if (sd.fault) begin
        qs[i] = '0;
      end else if (|quo[i][NUM_W-1:31]) begin
        qs[i] = sd.neg[i] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        qs[i] = sd.neg[i] ? $signed(32'd0 - quo[i][31:0]) : $signed(quo[i][31:0]);
      end
    end
  end

  // stage registers after the divider
  logic               va, vb, vc, vd, ve, vf, vg, vh, vi;
  logic [15:0]        id_a, id_b, id_c, id_d, id_e, id_f, id_g, id_h, id_i;
  logic               ft_a, ft_b, ft_c, ft_d, ft_e, ft_f, ft_g, ft_h, ft_i;
  logic signed [31:0] a_a [3];
  logic signed [31:0] p_a [3], p_b [3], p_c [3], p_d [3], p_e [3];
  logic signed [31:0] p_f [3], p_g [3], p_h [3], p_i [3];
  logic signed [31:0] v_a [3], v_b [3], v_c [3], v_d [3], v_e [3];
  logic signed [31:0] v_f [3], v_g [3], v_h [3], v_i [3];
  logic signed [63:0] m_b [3], m_d [3], m_f [3], m_h [3];
  logic               hit_f [3], hit_h [3];

  logic signed [63:0] pe64 [3], pg64 [3];
  logic               hit_fn [3], hit_hn [3];
  logic signed [31:0] p_fn [3], p_hn [3];

  for (genvar i = 0; i < 3; i++) begin : g_wall
    assign pe64[i] = sext64(p_e[i]);
    assign pg64[i] = sext64(p_g[i]);
    if (i == 1) begin : g_floor
      assign hit_fn[i] = pe64[i] < hh64;
      assign p_fn[i]   = hit_fn[i] ? sat32(2 * hh64 - pe64[i] + EPS64) : p_e[i];
      assign hit_hn[i] = 1'b0;
      assign p_hn[i]   = p_g[i];
    end else begin : g_side
      assign hit_fn[i] = pe64[i] < lo64;
      assign p_fn[i]   = hit_fn[i] ? sat32(2 * lo64 - pe64[i] + EPS64) : p_e[i];
      assign hit_hn[i] = pg64[i] > -lo64;
      assign p_hn[i]   = hit_hn[i] ? sat32(-2 * lo64 - pg64[i] - EPS64) : p_g[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0;
      vf <= 1'b0; vg <= 1'b0; vh <= 1'b0; vi <= 1'b0;
    end else if (en) begin
      va <= vld_q[NUM_W-1];
      vb <= va; vc <= vb; vd <= vc; ve <= vd;
      vf <= ve; vg <= vf; vh <= vg; vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id_a <= sd.id; id_b <= id_a; id_c <= id_b; id_d <= id_c; id_e <= id_d;
      id_f <= id_e; id_g <= id_f; id_h <= id_g; id_i <= id_h;
      ft_a <= sd.fault; ft_b <= ft_a; ft_c <= ft_b; ft_d <= ft_c; ft_e <= ft_d;
      ft_f <= ft_e; ft_g <= ft_f; ft_h <= ft_g; ft_i <= ft_h;

      a_a[0] <= qs[0];
      a_a[1] <= sat32(sext64(qs[1]) + sext64(gravity));
      a_a[2] <= qs[2];
      p_a[0] <= sd.px; p_a[1] <= sd.py; p_a[2] <= sd.pz;
      v_a[0] <= sd.vx; v_a[1] <= sd.vy; v_a[2] <= sd.vz;

      for (int i = 0; i < 3; i++) begin
        m_b[i] <= sext64(a_a[i]) * dt64;
        p_b[i] <= p_a[i];
        v_b[i] <= v_a[i];

        v_c[i] <= sat32(sext64(v_b[i]) + (m_b[i] >>> FRAC_BITS));
        p_c[i] <= p_b[i];

        m_d[i] <= sext64(v_c[i]) * dt64;
        v_d[i] <= v_c[i];
        p_d[i] <= p_c[i];

        p_e[i] <= sat32(sext64(p_d[i]) + (m_d[i] >>> FRAC_BITS));
        v_e[i] <= v_d[i];

        p_f[i]   <= p_fn[i];
        v_f[i]   <= v_e[i];
        hit_f[i] <= hit_fn[i];
        m_f[i]   <= (-sext64(v_e[i])) * e64;

        p_g[i] <= p_f[i];
        v_g[i] <= hit_f[i] ? sat32(m_f[i] >>> FRAC_BITS) : v_f[i];

        p_h[i]   <= p_hn[i];
        v_h[i]   <= v_g[i];
        hit_h[i] <= hit_hn[i];
        m_h[i]   <= (-sext64(v_g[i])) * e64;

        p_i[i] <= p_h[i];
        v_i[i] <= hit_h[i] ? sat32(m_h[i] >>> FRAC_BITS) : v_h[i];
      end
    end
  end

  assign out_valid     = vi;
  assign out_id        = id_i;
  assign new_pos_x     = p_i[0];
  assign new_pos_y     = p_i[1];
  assign new_pos_z     = p_i[2];
  assign new_vel_x     = v_i[0];
  assign new_vel_y     = v_i[1];
  assign new_vel_z     = v_i[2];
  assign density_fault = ft_i;

endmodule
`default_nettype wire

>>> tb/particle_integrate_box_bounce_checker.sv
// ----------------------------------------------------------------------------
// particle_integrate_box_bounce_checker
// Watches the config, particle and result channels of the integrator, keeps
// its own copy of the registers, predicts each updated particle and compares
// every field of each result in order. Reports a running mismatch count.
// ----------------------------------------------------------------------------
module particle_integrate_box_bounce_checker
  import pib_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] particle_id,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] force_x,
  input  logic [31:0] force_y,
  input  logic [31:0] force_z,
  input  logic [31:0] fluid_density,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_id,
  input  logic [31:0] new_pos_x,
  input  logic [31:0] new_pos_y,
  input  logic [31:0] new_pos_z,
  input  logic [31:0] new_vel_x,
  input  logic [31:0] new_vel_y,
  input  logic [31:0] new_vel_z,
  input  logic        density_fault,
  output int          fail_count,
  output int          pending,
  output int          seen,
  output int          faults_seen,
  output int          bounces_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] id;
    logic [31:0] p [3];
    logic [31:0] v [3];
    logic        fault;
  } particle_t;

  localparam longint EPS = 7;

  longint g_acc, dt, rad, half_w, elast;
  particle_t expected_q [$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor division by 2^16
  function automatic longint scale_down(longint x);
    return x >>> FRAC_BITS;
  endfunction

  function automatic particle_t integrate(logic [15:0] id, logic [31:0] pi [3],
                                          logic [31:0] vi [3], logic [31:0] fi [3],
                                          logic [31:0] dens);
    particle_t r;
    longint p [3], v [3], a [3];
    longint d, lo;
    bit flt;
    d = longint'(signed'(dens));
    flt = d <= 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'(signed'(pi[i]));
      v[i] = longint'(signed'(vi[i]));
      a[i] = flt ? 0 : clamp32((longint'(signed'(fi[i])) * 65536) / d);
    end
    a[1] = clamp32(a[1] + g_acc);
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp32(v[i] + scale_down(a[i] * dt));
      p[i] = clamp32(p[i] + scale_down(v[i] * dt));
    end
    if (p[1] < rad) begin
      p[1] = clamp32(2 * rad - p[1] + EPS);
      v[1] = clamp32(scale_down(-v[1] * elast));
    end
    lo = rad - half_w;
    for (int k = 0; k < 3; k += 2) begin
      if (p[k] < lo) begin
        p[k] = clamp32(2 * lo - p[k] + EPS);
        v[k] = clamp32(scale_down(-v[k] * elast));
      end
      if (p[k] > -lo) begin
        p[k] = clamp32(-2 * lo - p[k] - EPS);
        v[k] = clamp32(scale_down(-v[k] * elast));
      end
    end
    r.id = id;
    for (int i = 0; i < 3; i++) begin
      r.p[i] = p[i][31:0];
      r.v[i] = v[i][31:0];
    end
    r.fault = flt;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    particle_t e, got;
    logic [31:0] pin [3], vin [3], fin [3];
    if (rst) begin
      g_acc = -642253; dt = 655; rad = 6554; half_w = 196608; elast = 32768;
      expected_q.delete();
      fail_count = 0; seen = 0; faults_seen = 0; bounces_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY: g_acc = longint'(signed'(cfg_data));
          REG_DT:      dt = longint'(cfg_data[30:0]);
          REG_RADIUS:  rad = longint'(cfg_data[30:0]);
          REG_HALF_W:  half_w = longint'(cfg_data[30:0]);
          REG_BOUNCE:  elast = longint'(cfg_data[16:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen++;
        if (expected_q.size() == 0) begin
          $display("mismatch %0t: result with nothing expected", $realtime);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          got.p = '{new_pos_x, new_pos_y, new_pos_z};
          got.v = '{new_vel_x, new_vel_y, new_vel_z};
          if (out_id !== e.id) report("out_id", out_id, e.id);
          for (int i = 0; i < 3; i++) begin
            if (got.p[i] !== e.p[i]) report($sformatf("new_pos[%0d]", i), got.p[i], e.p[i]);
            if (got.v[i] !== e.v[i]) report($sformatf("new_vel[%0d]", i), got.v[i], e.v[i]);
          end
          if (density_fault !== e.fault) report("density_fault", density_fault, e.fault);
          if (e.fault) faults_seen++;
        end
      end
      if (in_valid && in_ready) begin
        pin = '{pos_x, pos_y, pos_z};
        vin = '{vel_x, vel_y, vel_z};
        fin = '{force_x, force_y, force_z};
        e = integrate(particle_id, pin, vin, fin, fluid_density);
        if (e.v[1] != vin[1] && e.p[1] != pin[1] && signed'(e.p[1]) >= rad) bounces_seen++;
        expected_q.push_back(e);
      end
    end
    pending = expected_q.size();
  end
endmodule

>>> tb/particle_integrate_box_bounce_core_test.sv
// ----------------------------------------------------------------------------
// particle_integrate_box_bounce_core_test
// Drives directed and random particles through the integrator under several
// register settings with random idling and a long output stall; the checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------
module particle_integrate_box_bounce_core_test;
  import pib_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = NUM_W + 9;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [15:0] particle_id = '0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, vel_x = '0, vel_y = '0, vel_z = '0;
  logic [31:0] force_x = '0, force_y = '0, force_z = '0, fluid_density = '0;
  logic out_valid, out_ready = 0;
  logic [15:0] out_id;
  logic [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic density_fault;
  int fail_count, pending, seen, faults_seen, bounces_seen;
  bit calm = 0, hold_off = 0;
  int requests_sent = 0;

  always #5 clk = ~clk;

  particle_integrate_box_bounce_core i_dut (.*);
  particle_integrate_box_bounce_checker i_chk (.*);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 800000)) - 400000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 60000)) - 30000);
    endcase
  endfunction

  // valid stays high after a request; it drops on an idle burst or in drain()
  task automatic send(logic [15:0] id, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                      logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                      logic [31:0] dens);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1; particle_id <= id;
    pos_x <= px; pos_y <= py; pos_z <= pz; vel_x <= vx; vel_y <= vy; vel_z <= vz;
    force_x <= fx; force_y <= fy; force_z <= fz; fluid_density <= dens;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic random_particle();
    int k;
    logic [31:0] dens;
    k = $urandom_range(0, 9);
    if (k < 6) k = 1; else if (k < 8) k = 3; else if (k == 8) k = 0; else k = 2;
    case ($urandom_range(0, 9))
      0: dens = $urandom_range(0, 1) ? 32'h0 : 32'h80000000 | $urandom;
      1: dens = $urandom;
      2: dens = $urandom_range(1, 3);
      default: dens = $urandom_range(16384, 200000);
    endcase
    send($urandom, rnd_coord(k), rnd_coord(k), rnd_coord(k), rnd_coord(k), rnd_coord(k),
         rnd_coord(k), rnd_coord($urandom_range(0, 3)), rnd_coord($urandom_range(0, 3)),
         rnd_coord($urandom_range(0, 3)), dens);
  endtask

  // output side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else if (calm) out_ready <= 1;
    else if ($urandom_range(0, 7) == 0) out_ready <= 0;
    else out_ready <= 1;
  end

  initial begin
    repeat (200) @(posedge clk);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, density faults, walls, saturation
    send(16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h10000);
    send(16'h0000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
    send(16'h1234, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1);
    send(1, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0);
    send(2, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000,
         32'h80000000);
    send(3, 0, 32'hffff0000, 0, 32'h10000, 32'hfff00000, 0, 0, 0, 0, 32'h10000);
    send(4, 32'hfffc0000, 32'h10000, 32'h40000, 32'hfff00000, 0, 32'h100000, 0, 0, 0, 32'h10000);
    send(5, 32'h40000, 32'h10000, 32'hfffc0000, 32'h100000, 0, 32'hfff00000, 0, 0, 0, 32'h10000);
    send(6, 0, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    drain();
    // extremes of the registers
    write_reg(REG_GRAVITY, 32'h7fffffff);
    write_reg(REG_DT, 32'hffffffff);
    write_reg(REG_RADIUS, 32'h7fffffff);
    write_reg(REG_HALF_W, 0);
    write_reg(REG_BOUNCE, 32'h1ffff);
    repeat (40) random_particle();
    drain();
    // radius above half width: walls cross
    write_reg(REG_GRAVITY, 32'h80000000);
    write_reg(REG_DT, 32'h10000);
    write_reg(REG_RADIUS, 32'h30000);
    write_reg(REG_HALF_W, 32'h10000);
    write_reg(REG_BOUNCE, 0);
    repeat (60) random_particle();
    drain();
    write_reg(REG_GRAVITY, 0);
    write_reg(REG_DT, 0);
    write_reg(REG_RADIUS, 0);
    write_reg(REG_HALF_W, 32'h7fffffff);
    write_reg(REG_BOUNCE, 32'h10000);
    repeat (60) random_particle();
    drain();
    write_reg(REG_GRAVITY, 32'hfff63333);
    write_reg(REG_DT, 32'h1000);
    write_reg(REG_RADIUS, 6554);
    write_reg(REG_HALF_W, 32'h30000);
    write_reg(REG_BOUNCE, 32'h18000);
    repeat (300) random_particle();
    drain();
    write_reg(REG_GRAVITY, $urandom);
    write_reg(REG_DT, $urandom_range(1, 32'h8000));
    write_reg(REG_RADIUS, $urandom_range(0, 32'h20000));
    write_reg(REG_HALF_W, $urandom_range(0, 32'h80000));
    write_reg(REG_BOUNCE, $urandom_range(0, 32'h1ffff));
    repeat (150) random_particle();
    calm = 1;
    repeat (80) random_particle();
    drain();
    $display("sent %0d particles, checked %0d results (%0d density faults)",
             requests_sent, seen, faults_seen);
    $display("register settings covered extremes, crossed walls and bounce above one");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
